// ----- hw/rtl/multi_channel_message_ring_macros.svh -----
// ----------------------------------------------------------------------------
// multi channel message ring assertion macros
// concurrent assertion wrappers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_MESSAGE_RING_MACROS_SVH
`define MULTI_CHANNEL_MESSAGE_RING_MACROS_SVH

`ifndef SYNTHESIS
// plain property check
`define MCMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// antecedent implies consequent in the next cycle
`define MCMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  `MCMR_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define MCMR_ASSERT(lbl, prop, msg)
`define MCMR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/mcmr_pkg.sv -----
// ----------------------------------------------------------------------------
// mcmr_pkg
// shared types and constants of the multi channel message ring
// ----------------------------------------------------------------------------
package mcmr_pkg;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CH_FIELD_W  = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned WCNT_W      = 8;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_NO_ROOM = 3'd2,
    ST_COMMIT  = 3'd3,
    ST_REJECT  = 3'd4
  } status_e;

  // strobes from the sequencer to the slot store
  typedef struct packed {
    logic len_we;
    logic len_re;
    logic byte_we;
    logic byte_re;
  } mem_ctl_t;

endpackage

// ----- hw/rtl/mcmr_store.sv -----
// ----------------------------------------------------------------------------
// mcmr_store
// slot length and message byte memories, one write and one registered read
// ----------------------------------------------------------------------------
module mcmr_store #(
  parameter int unsigned LA_W = 5,
  parameter int unsigned BA_W = 11
) (
  input  logic                        clk_i,
  input  mcmr_pkg::mem_ctl_t          ctl_i,
  input  logic [LA_W-1:0]             len_waddr_i,
  input  logic [mcmr_pkg::LEN_W-1:0]  len_wdata_i,
  input  logic [LA_W-1:0]             len_raddr_i,
  output logic [mcmr_pkg::LEN_W-1:0]  len_rdata_o,
  input  logic [BA_W-1:0]             byte_waddr_i,
  input  logic [mcmr_pkg::BYTE_W-1:0] byte_wdata_i,
  input  logic [BA_W-1:0]             byte_raddr_i,
  output logic [mcmr_pkg::BYTE_W-1:0] byte_rdata_o
);

  logic [mcmr_pkg::LEN_W-1:0]  len_mem  [2**LA_W];
  logic [mcmr_pkg::BYTE_W-1:0] byte_mem [2**BA_W];

  always_ff @(posedge clk_i) begin
    if (ctl_i.len_we) begin
      len_mem[len_waddr_i] <= len_wdata_i;
    end
    if (ctl_i.len_re) begin
      len_rdata_o <= len_mem[len_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.byte_we) begin
      byte_mem[byte_waddr_i] <= byte_wdata_i;
    end
    if (ctl_i.byte_re) begin
      byte_rdata_o <= byte_mem[byte_raddr_i];
    end
  end

endmodule

// ----- hw/rtl/multi_channel_message_ring.sv -----
// ----------------------------------------------------------------------------
// multi_channel_message_ring
// per-channel rings of message slots, written a byte per word, read as runs
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (low first)                       tuser    tlast
//  s_axis   in   channel, msg_len, data_byte, read_room (32b)   action   -
//  m_axis   out  out_byte, msg_length (16b)                     status   last
//
//  every input word is accepted, then handled in one evaluation step that
//  uses the registered slot length read
//  a read that streams bytes alternates a registered read of the byte
//  memory with an emit, one byte per read-emit pair
//  a full output register holds the sequencer until m_axis takes the word
//  reset clears ring pointers, fill counts and write counters; no memory pass
// ----------------------------------------------------------------------------
`include "multi_channel_message_ring_macros.svh"

module multi_channel_message_ring #(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned DEPTH     = 8,
  parameter int unsigned MSG_BYTES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // channel[1:0], msg_len[9:2], data_byte[17:10], read_room[25:18], zero above
  input  logic [mcmr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action[0]
  input  logic [0:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // out_byte[7:0], msg_length[14:8], zero above
  output logic [mcmr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]                       m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SL_W = $clog2(DEPTH);
  localparam int unsigned BY_W = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int unsigned OC_W = $clog2(DEPTH + 1);
  localparam int unsigned LA_W = CH_W + SL_W;
  localparam int unsigned BA_W = LA_W + BY_W;
  localparam int unsigned LW   = mcmr_pkg::LEN_W;
  localparam int unsigned WW   = mcmr_pkg::WCNT_W;
  localparam int unsigned BW   = mcmr_pkg::BYTE_W;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EVAL,
    FSM_RD_ISSUE,
    FSM_RD_EMIT
  } state_e;

  state_e state_q, state_d;

  // per-channel ring state
  logic [SL_W-1:0] head_q [CHANNELS];
  logic [SL_W-1:0] head_d [CHANNELS];
  logic [SL_W-1:0] tail_q [CHANNELS];
  logic [SL_W-1:0] tail_d [CHANNELS];
  logic [OC_W-1:0] occ_q  [CHANNELS];
  logic [OC_W-1:0] occ_d  [CHANNELS];
  logic [WW-1:0]   wcnt_q [CHANNELS];
  logic [WW-1:0]   wcnt_d [CHANNELS];
  logic            disc_q [CHANNELS];
  logic            disc_d [CHANNELS];

  // latched word
  logic            act_q, act_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic            ch_ok_q, ch_ok_d;
  logic [BW-1:0]   mlen_q, mlen_d;
  logic [BW-1:0]   db_q, db_d;
  logic [BW-1:0]   room_q, room_d;
  logic [SL_W-1:0] slot_q, slot_d;

  // read streaming
  logic [LW-1:0]   rd_len_q, rd_len_d;
  logic [LW-1:0]   rd_idx_q, rd_idx_d;

  // output register
  logic            out_valid_q, out_valid_d;
  logic [2:0]      out_status_q, out_status_d;
  logic [BW-1:0]   out_byte_q, out_byte_d;
  logic [LW-1:0]   out_len_q, out_len_d;
  logic            out_last_q, out_last_d;

  // input fields
  logic                          in_act;
  logic [mcmr_pkg::CH_FIELD_W-1:0] in_ch;
  logic [BW-1:0]                 in_mlen, in_db, in_room;
  logic                          in_accept, in_ch_ok;
  logic [CH_W-1:0]               in_ch_idx;

  // store interface
  mcmr_pkg::mem_ctl_t mem_ctl;
  logic [LA_W-1:0]    len_raddr;
  logic [LW-1:0]      len_rdata;
  logic [BY_W-1:0]    byte_widx;
  logic [BW-1:0]      byte_rdata;

  // evaluation helpers
  logic [WW-1:0]   cur_wc;
  logic            cur_disc;
  logic [OC_W-1:0] cur_occ;
  logic            w_reject, wr_emit, rd_emit, eval_emit, out_free;
  logic [WW-1:0]   wr_idx;
  logic [SL_W-1:0] slot_next;

  assign in_act    = s_axis_tuser_i[0];
  assign in_ch     = s_axis_tdata_i[1:0];
  assign in_mlen   = s_axis_tdata_i[9:2];
  assign in_db     = s_axis_tdata_i[17:10];
  assign in_room   = s_axis_tdata_i[25:18];
  assign in_ch_ok  = (32'(in_ch) < CHANNELS);
  assign in_ch_idx = in_ch_ok ? CH_W'(in_ch) : '0;

  assign s_axis_tready_o = (state_q == FSM_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign len_raddr = {in_ch_idx,
                      (in_act == mcmr_pkg::ACT_READ) ? tail_q[in_ch_idx] : head_q[in_ch_idx]};

  assign cur_wc    = wcnt_q[ch_q];
  assign cur_disc  = disc_q[ch_q];
  assign cur_occ   = occ_q[ch_q];
  assign slot_next = (slot_q == SL_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  assign w_reject  = (32'(mlen_q) > MSG_BYTES) || (cur_occ == OC_W'(DEPTH));
  assign wr_emit   = (cur_wc == '0) ? (w_reject || (mlen_q <= 8'd1))
                                    : (!cur_disc && (cur_wc == 8'd1));
  assign rd_emit   = (cur_occ == '0) || ({1'b0, len_rdata} > room_q) || (len_rdata == '0);
  assign eval_emit = ch_ok_q && ((act_q == mcmr_pkg::ACT_WRITE) ? wr_emit : rd_emit);

  // byte position of the current write; zero on the first byte
  assign wr_idx    = (cur_wc == '0) ? '0 : WW'(len_rdata) - cur_wc;
  assign byte_widx = wr_idx[BY_W-1:0];

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    occ_d        = occ_q;
    wcnt_d       = wcnt_q;
    disc_d       = disc_q;
    act_d        = act_q;
    ch_d         = ch_q;
    ch_ok_d      = ch_ok_q;
    mlen_d       = mlen_q;
    db_d         = db_q;
    room_d       = room_q;
    slot_d       = slot_q;
    rd_len_d     = rd_len_q;
    rd_idx_d     = rd_idx_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_byte_d   = out_byte_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;
    mem_ctl      = '0;

    case (state_q)
      FSM_IDLE: begin
        if (in_accept) begin
          mem_ctl.len_re = 1'b1;
          act_d   = in_act;
          ch_d    = in_ch_idx;
          ch_ok_d = in_ch_ok;
          mlen_d  = in_mlen;
          db_d    = in_db;
          room_d  = in_room;
          slot_d  = (in_act == mcmr_pkg::ACT_READ) ? tail_q[in_ch_idx] : head_q[in_ch_idx];
          state_d = FSM_EVAL;
        end
      end

      FSM_EVAL: begin
        if (!eval_emit || out_free) begin
          state_d = FSM_IDLE;
          if (eval_emit) begin
            out_valid_d  = 1'b1;
            out_byte_d   = '0;
            out_last_d   = 1'b1;
          end
          if (!ch_ok_q) begin
            // item for a channel that does not exist is dropped
          end else if (act_q == mcmr_pkg::ACT_WRITE) begin
            if (cur_wc == '0) begin
              if (w_reject) begin
                wcnt_d[ch_q] = (mlen_q == '0) ? '0 : mlen_q - 1'b1;
                disc_d[ch_q] = (mlen_q > 8'd1);
                out_status_d = mcmr_pkg::ST_REJECT;
                out_len_d    = mlen_q[7] ? 7'd127 : mlen_q[6:0];
              end else begin
                mem_ctl.len_we = 1'b1;
                if (mlen_q != '0) begin
                  mem_ctl.byte_we = 1'b1;
                  wcnt_d[ch_q]    = mlen_q - 1'b1;
                  disc_d[ch_q]    = 1'b0;
                end
                if (mlen_q <= 8'd1) begin
                  occ_d[ch_q]  = cur_occ + 1'b1;
                  head_d[ch_q] = slot_next;
                  out_status_d = mcmr_pkg::ST_COMMIT;
                  out_len_d    = mlen_q[LW-1:0];
                end
              end
            end else if (cur_disc) begin
              wcnt_d[ch_q] = cur_wc - 1'b1;
              if (cur_wc == 8'd1) begin
                disc_d[ch_q] = 1'b0;
              end
            end else begin
              mem_ctl.byte_we = 1'b1;
              wcnt_d[ch_q]    = cur_wc - 1'b1;
              if (cur_wc == 8'd1) begin
                occ_d[ch_q]  = cur_occ + 1'b1;
                head_d[ch_q] = slot_next;
                out_status_d = mcmr_pkg::ST_COMMIT;
                out_len_d    = len_rdata;
              end
            end
          end else begin
            // emptiness first, then room
            if (cur_occ == '0) begin
              out_status_d = mcmr_pkg::ST_EMPTY;
              out_len_d    = '0;
            end else if ({1'b0, len_rdata} > room_q) begin
              out_status_d = mcmr_pkg::ST_NO_ROOM;
              out_len_d    = len_rdata;
            end else begin
              occ_d[ch_q]  = cur_occ - 1'b1;
              tail_d[ch_q] = slot_next;
              if (len_rdata == '0) begin
                out_status_d = mcmr_pkg::ST_BYTE;
                out_len_d    = '0;
              end else begin
                rd_len_d = len_rdata;
                rd_idx_d = '0;
                state_d  = FSM_RD_ISSUE;
              end
            end
          end
        end
      end

      FSM_RD_ISSUE: begin
        mem_ctl.byte_re = 1'b1;
        state_d         = FSM_RD_EMIT;
      end

      FSM_RD_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = mcmr_pkg::ST_BYTE;
          out_byte_d   = byte_rdata;
          out_len_d    = rd_len_q;
          out_last_d   = (rd_idx_q + 1'b1 == rd_len_q);
          rd_idx_d     = rd_idx_q + 1'b1;
          state_d      = (rd_idx_q + 1'b1 == rd_len_q) ? FSM_IDLE : FSM_RD_ISSUE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
        wcnt_q[i] <= '0;
        disc_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      wcnt_q      <= wcnt_d;
      disc_q      <= disc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    ch_q         <= ch_d;
    ch_ok_q      <= ch_ok_d;
    mlen_q       <= mlen_d;
    db_q         <= db_d;
    room_q       <= room_d;
    slot_q       <= slot_d;
    rd_len_q     <= rd_len_d;
    rd_idx_q     <= rd_idx_d;
    out_status_q <= out_status_d;
    out_byte_q   <= out_byte_d;
    out_len_q    <= out_len_d;
    out_last_q   <= out_last_d;
  end

  mcmr_store #(
    .LA_W (LA_W),
    .BA_W (BA_W)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .len_waddr_i  ({ch_q, slot_q}),
    .len_wdata_i  (mlen_q[LW-1:0]),
    .len_raddr_i  (len_raddr),
    .len_rdata_o  (len_rdata),
    .byte_waddr_i ({ch_q, slot_q, byte_widx}),
    .byte_wdata_i (db_q),
    .byte_raddr_i ({ch_q, slot_q, rd_idx_q[BY_W-1:0]}),
    .byte_rdata_o (byte_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_len_q, out_byte_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  `MCMR_ASSERT_NEXT(a_accept_to_eval, in_accept, state_q == FSM_EVAL, "accept did not start eval")
  `MCMR_ASSERT(a_occ_bound, state_q == FSM_EVAL |-> cur_occ <= OC_W'(DEPTH), "fill count overflow")
  `MCMR_ASSERT(a_rd_idx, state_q == FSM_RD_ISSUE |-> rd_idx_q < rd_len_q, "read index past length")
  `MCMR_ASSERT(a_status_last, m_axis_tvalid_o && m_axis_tuser_o != mcmr_pkg::ST_BYTE |-> m_axis_tlast_o, "status word without last")
  `MCMR_ASSERT_NEXT(a_emit_hold, state_q == FSM_RD_EMIT && m_axis_tvalid_o && !m_axis_tready_i, state_q == FSM_RD_EMIT, "byte emitted into full register")

endmodule
